[hw/rtl/voice_command_queue_controller_top_macros.svh]
// Assertion macros shared by the queue controller RTL.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef VOICE_COMMAND_QUEUE_CONTROLLER_TOP_MACROS_SVH
`define VOICE_COMMAND_QUEUE_CONTROLLER_TOP_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define VCQC_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("vcqc: assertion failed");

// An antecedent that implies a consequent at the same edge.
`define VCQC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vcqc: implication failed");

`endif

[hw/rtl/vcqc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package vcqc_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CHINESE_GROUP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENGLISH_GROUP = 2'd1;
  localparam logic [3:0] GROUP_RESET = 4'd6;

  localparam logic [3:0] MODE_APPEND     = 4'd0;
  localparam logic [3:0] MODE_TICK       = 4'd1;
  localparam logic [3:0] MODE_PLAY_NOW   = 4'd2;
  localparam logic [3:0] MODE_SEL_GROUP  = 4'd3;
  localparam logic [3:0] MODE_VOLUME     = 4'd4;
  localparam logic [3:0] MODE_PAUSE      = 4'd5;
  localparam logic [3:0] MODE_RESUME     = 4'd6;
  localparam logic [3:0] MODE_STOP       = 4'd7;
  localparam logic [3:0] MODE_START_LIST = 4'd8;
  localparam logic [3:0] MODE_STOP_LIST  = 4'd9;
  localparam logic [3:0] MODE_CLEAR      = 4'd10;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BUSY  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [3:0] BITS_4  = 4'd4;
  localparam logic [3:0] BITS_8  = 4'd8;
  localparam logic [3:0] BITS_12 = 4'd12;

  localparam logic [11:0] FRM_SEL_GROUP  = 12'h060;
  localparam logic [11:0] FRM_PLAY_GROUP = 12'h070;
  localparam logic [11:0] FRM_SEL_VOICE  = 12'hA00;
  localparam logic [11:0] FRM_VOLUME     = 12'h040;
  localparam logic [11:0] FRM_PAUSE      = 12'h000;
  localparam logic [11:0] FRM_RESUME     = 12'h002;
  localparam logic [11:0] FRM_STOP       = 12'h003;

  localparam logic [3:0] GROUP_MIN  = 4'd1;
  localparam logic [3:0] GROUP_MAX  = 4'd8;
  localparam logic [3:0] VOLUME_MAX = 4'd7;
  localparam logic [7:0] INDEX_MIN  = 8'd1;
  localparam logic [7:0] INDEX_MAX  = 8'd254;

  // One queued request.
  typedef struct packed {
    logic       language;
    logic       wait_flag;
    logic [7:0] voice_index;
  } entry_t;

  // One result beat.
  typedef struct packed {
    logic        frame_valid;
    logic [3:0]  frame_bits;
    logic [11:0] frame_word;
    logic [1:0]  status;
    logic        last;
  } res_t;

  function automatic logic group_ok(input logic [3:0] g);
    return (g >= GROUP_MIN) && (g <= GROUP_MAX);
  endfunction

  function automatic res_t mk_frame(input logic [3:0] bits, input logic [11:0] word);
    res_t r;
    r.frame_valid = 1'b1;
    r.frame_bits  = bits;
    r.frame_word  = word;
    r.status      = ST_OK;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_status(input logic [1:0] st);
    res_t r;
    r.frame_valid = 1'b0;
    r.frame_bits  = 4'd0;
    r.frame_word  = 12'd0;
    r.status      = st;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/vcqc_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// One place of the request queue. On a pop every cell takes its upstream
// neighbour's entry, so the head always sits in the first cell.
module vcqc_cell (
  input  wire logic            clk,
  input  wire logic            load,
  input  wire logic            shift,
  input  wire vcqc_pkg::entry_t d_load,
  input  wire vcqc_pkg::entry_t d_next,
  output vcqc_pkg::entry_t     q
);

  vcqc_pkg::entry_t entry_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      entry_r <= d_next;
    end else if (load) begin
      entry_r <= d_load;
    end
  end

  assign q = entry_r;

endmodule
`default_nettype wire

[hw/rtl/voice_command_queue_controller_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Voice command queue controller.
// Input channel (in_*): one command beat per item, taken with in_valid and in_ready.
// Result channel (out_*): one to three beats per item; out_last marks the final one.
// Configuration channel (cfg_*): cfg_ready is always high; index 0 sets the group
// for first-language requests, index 1 for second-language ones, others are ignored.
// An item is decoded in the cycle it is accepted; its results are then moved from
// a three-entry result buffer into the output register one per cycle while the
// receiver does not stall. The next item is taken as soon as the last beat has
// reached the output register. Requests live in a row of QUEUE_DEPTH cells; a
// tick that plays the head shifts the whole row by one. A stalled receiver holds
// the output register and, while beats of the item are still to move, holds
// in_ready low. Reset empties the queue, disables the list, clears the current
// group and sets both language groups to 6; no clearing pass is needed.
`include "voice_command_queue_controller_top_macros.svh"
module voice_command_queue_controller_top #(
  parameter int QUEUE_DEPTH = vcqc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [3:0]                     in_mode,
  input  wire logic [7:0]                     in_voice_index,
  input  wire logic                           in_wait_flag,
  input  wire logic                           in_language,
  input  wire logic [3:0]                     in_group_number,
  input  wire logic [3:0]                     in_volume_level,
  input  wire logic                           in_device_busy,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_frame_valid,
  output logic [3:0]                          out_frame_bits,
  output logic [11:0]                         out_frame_word,
  output logic [1:0]                          out_status,
  output logic                                out_last,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [vcqc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [3:0]                     cfg_wdata
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic [3:0]       chi_group_r;
  logic [3:0]       eng_group_r;
  logic [CNT_W-1:0] cnt_r;
  logic             list_en_r;
  logic             list_en_nxt;
  logic [3:0]       cur_group_r;
  logic [3:0]       cur_group_nxt;

  logic             state_r;
  logic [1:0]       idx_r;
  logic [1:0]       n_r;
  logic [1:0]       n_nxt;
  vcqc_pkg::res_t   buf_r [3];
  vcqc_pkg::res_t   buf_nxt [3];
  vcqc_pkg::res_t   out_res_r;
  logic             out_valid_r;
  logic             out_load;

  logic             in_fire;
  logic             push_c;
  logic             pop_c;
  logic             clr_c;

  vcqc_pkg::entry_t cell_q [QUEUE_DEPTH];
  vcqc_pkg::entry_t head;
  vcqc_pkg::entry_t new_entry;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign head      = cell_q[0];

  assign new_entry.language    = in_language;
  assign new_entry.wait_flag   = in_wait_flag;
  assign new_entry.voice_index = in_voice_index;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      vcqc_pkg::entry_t d_next;
      if (gi == QUEUE_DEPTH - 1) begin : g_tail
        assign d_next = '0;
      end else begin : g_mid
        assign d_next = cell_q[gi + 1];
      end
      vcqc_cell u_cell (
        .clk    (clk),
        .load   (in_fire && push_c && (cnt_r == CNT_W'(gi))),
        .shift  (in_fire && pop_c),
        .d_load (new_entry),
        .d_next (d_next),
        .q      (cell_q[gi])
      );
    end
  endgenerate

  // Decode of the accepted command into up to three candidate frames.
  always_comb begin
    vcqc_pkg::res_t cand [3];
    logic [2:0]     cand_en;
    logic [1:0]     status;
    logic [3:0]     lang_group;
    logic [3:0]     play_group;
    logic           idx_ok;
    logic [1:0]     n;

    for (int k = 0; k < 3; k++) begin
      cand[k]    = vcqc_pkg::mk_status(vcqc_pkg::ST_OK);
      buf_nxt[k] = vcqc_pkg::mk_status(vcqc_pkg::ST_OK);
    end
    cand_en       = 3'b000;
    status        = vcqc_pkg::ST_OK;
    list_en_nxt   = list_en_r;
    cur_group_nxt = cur_group_r;
    push_c        = 1'b0;
    pop_c         = 1'b0;
    clr_c         = 1'b0;
    lang_group    = head.language ? eng_group_r : chi_group_r;
    play_group    = vcqc_pkg::group_ok(lang_group) ? lang_group : cur_group_r;
    idx_ok        = (in_voice_index >= vcqc_pkg::INDEX_MIN) &&
                    (in_voice_index <= vcqc_pkg::INDEX_MAX);

    unique case (in_mode)
      vcqc_pkg::MODE_APPEND: begin
        if (!idx_ok) begin
          status = vcqc_pkg::ST_RANGE;
        end else if (cnt_r == CNT_W'(QUEUE_DEPTH)) begin
          status = vcqc_pkg::ST_FULL;
        end else begin
          push_c = 1'b1;
        end
      end
      vcqc_pkg::MODE_TICK: begin
        if ((cnt_r != '0) && list_en_r) begin
          if (head.wait_flag && in_device_busy) begin
            status = vcqc_pkg::ST_BUSY;
          end else begin
            if (vcqc_pkg::group_ok(lang_group)) begin
              cand[0]       = vcqc_pkg::mk_frame(vcqc_pkg::BITS_8,
                                vcqc_pkg::FRM_SEL_GROUP | {8'd0, lang_group});
              cand_en[0]    = 1'b1;
              cur_group_nxt = lang_group;
            end
            cand[1]    = vcqc_pkg::mk_frame(vcqc_pkg::BITS_12,
                           vcqc_pkg::FRM_SEL_VOICE | {4'd0, head.voice_index});
            cand_en[1] = 1'b1;
            cand[2]    = vcqc_pkg::mk_frame(vcqc_pkg::BITS_8,
                           vcqc_pkg::FRM_PLAY_GROUP | {8'd0, play_group});
            cand_en[2] = vcqc_pkg::group_ok(play_group);
            pop_c      = 1'b1;
          end
        end
      end
      vcqc_pkg::MODE_PLAY_NOW: begin
        if (!idx_ok) begin
          status = vcqc_pkg::ST_RANGE;
        end else if (in_wait_flag && in_device_busy) begin
          status = vcqc_pkg::ST_BUSY;
        end else begin
          cand[1]    = vcqc_pkg::mk_frame(vcqc_pkg::BITS_12,
                         vcqc_pkg::FRM_SEL_VOICE | {4'd0, in_voice_index});
          cand_en[1] = 1'b1;
          cand[2]    = vcqc_pkg::mk_frame(vcqc_pkg::BITS_8,
                         vcqc_pkg::FRM_PLAY_GROUP | {8'd0, cur_group_r});
          cand_en[2] = vcqc_pkg::group_ok(cur_group_r);
        end
      end
      vcqc_pkg::MODE_SEL_GROUP: begin
        if (!vcqc_pkg::group_ok(in_group_number)) begin
          status = vcqc_pkg::ST_RANGE;
        end else begin
          cand[0]       = vcqc_pkg::mk_frame(vcqc_pkg::BITS_8,
                            vcqc_pkg::FRM_SEL_GROUP | {8'd0, in_group_number});
          cand_en[0]    = 1'b1;
          cur_group_nxt = in_group_number;
        end
      end
      vcqc_pkg::MODE_VOLUME: begin
        if (in_volume_level > vcqc_pkg::VOLUME_MAX) begin
          status = vcqc_pkg::ST_RANGE;
        end else begin
          cand[0]     = vcqc_pkg::mk_frame(vcqc_pkg::BITS_4, vcqc_pkg::FRM_PAUSE);
          cand[1]     = vcqc_pkg::mk_frame(vcqc_pkg::BITS_8,
                          vcqc_pkg::FRM_VOLUME | {8'd0, in_volume_level});
          cand[2]     = vcqc_pkg::mk_frame(vcqc_pkg::BITS_4, vcqc_pkg::FRM_RESUME);
          cand_en     = 3'b111;
          list_en_nxt = 1'b1;
        end
      end
      vcqc_pkg::MODE_PAUSE: begin
        cand[0]     = vcqc_pkg::mk_frame(vcqc_pkg::BITS_4, vcqc_pkg::FRM_PAUSE);
        cand_en[0]  = 1'b1;
        list_en_nxt = 1'b0;
      end
      vcqc_pkg::MODE_RESUME: begin
        cand[0]     = vcqc_pkg::mk_frame(vcqc_pkg::BITS_4, vcqc_pkg::FRM_RESUME);
        cand_en[0]  = 1'b1;
        list_en_nxt = 1'b1;
      end
      vcqc_pkg::MODE_STOP: begin
        cand[0]     = vcqc_pkg::mk_frame(vcqc_pkg::BITS_4, vcqc_pkg::FRM_STOP);
        cand_en[0]  = 1'b1;
        list_en_nxt = 1'b0;
      end
      vcqc_pkg::MODE_START_LIST: begin
        list_en_nxt = 1'b1;
      end
      vcqc_pkg::MODE_STOP_LIST: begin
        list_en_nxt = 1'b0;
      end
      vcqc_pkg::MODE_CLEAR: begin
        clr_c       = 1'b1;
        list_en_nxt = 1'b0;
      end
      default: begin
        status = vcqc_pkg::ST_RANGE;
      end
    endcase

    // Pack the enabled frames to the front of the result buffer.
    n = 2'd0;
    for (int k = 0; k < 3; k++) begin
      if (cand_en[k]) begin
        buf_nxt[n] = cand[k];
        n          = n + 2'd1;
      end
    end
    if (n == 2'd0) begin
      buf_nxt[0] = vcqc_pkg::mk_status(status);
      n          = 2'd1;
    end
    buf_nxt[n - 2'd1].last = 1'b1;
    n_nxt = n;
  end

  // Configuration and list state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chi_group_r <= vcqc_pkg::GROUP_RESET;
      eng_group_r <= vcqc_pkg::GROUP_RESET;
      cnt_r       <= '0;
      list_en_r   <= 1'b0;
      cur_group_r <= 4'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          vcqc_pkg::REG_CHINESE_GROUP: chi_group_r <= cfg_wdata;
          vcqc_pkg::REG_ENGLISH_GROUP: eng_group_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        list_en_r   <= list_en_nxt;
        cur_group_r <= cur_group_nxt;
        if (clr_c) begin
          cnt_r <= '0;
        end else if (push_c) begin
          cnt_r <= cnt_r + 1'b1;
        end else if (pop_c) begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Result buffer drained into the output register one beat per cycle unless stalled.
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= 2'd0;
      n_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r <= ST_EMIT;
        idx_r   <= 2'd0;
        n_r     <= n_nxt;
      end else if (out_load) begin
        idx_r <= idx_r + 2'd1;
        if (idx_r == n_r - 2'd1) begin
          state_r <= ST_IDLE;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int k = 0; k < 3; k++) begin
        buf_r[k] <= buf_nxt[k];
      end
    end
    if (out_load) begin
      out_res_r <= buf_r[idx_r];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_valid = out_res_r.frame_valid;
  assign out_frame_bits  = out_res_r.frame_bits;
  assign out_frame_word  = out_res_r.frame_word;
  assign out_status      = out_res_r.status;
  assign out_last        = out_res_r.last;

  `VCQC_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(QUEUE_DEPTH))
  `VCQC_ASSERT_IMP(a_emit_index, state_r == ST_EMIT, (idx_r < n_r) && (n_r != 2'd0))
  `VCQC_ASSERT(a_emit_after_accept, in_fire |=> (state_r == ST_EMIT) && (idx_r == 2'd0))
  `VCQC_ASSERT(a_pop_count, (in_fire && pop_c) |=> cnt_r == $past(cnt_r) - 1'b1)

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;

  localparam int LONG_HOLD = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PER_PHASE = 22;
  localparam logic [vcqc_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 2'd2;
  localparam logic [vcqc_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 2'd3;
  localparam logic [3:0] MODE_UNKNOWN_LO = 4'd11;
  localparam logic [3:0] MODE_UNKNOWN_HI = 4'd15;

  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] voice_index;
    logic       wait_flag;
    logic       language;
    logic [3:0] group_number;
    logic [3:0] volume_level;
    logic       device_busy;
  } cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] in_mode = '0;
  logic [7:0] in_voice_index = '0;
  logic in_wait_flag = 1'b0;
  logic in_language = 1'b0;
  logic [3:0] in_group_number = '0;
  logic [3:0] in_volume_level = '0;
  logic in_device_busy = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_frame_valid;
  logic [3:0] out_frame_bits;
  logic [11:0] out_frame_word;
  logic [1:0] out_status;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [vcqc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [3:0] cfg_wdata = '0;

  // Shadow state of the controller.
  vcqc_pkg::entry_t request_fifo[$];
  logic [3:0] lang_group[2] = '{vcqc_pkg::GROUP_RESET, vcqc_pkg::GROUP_RESET};
  logic [3:0] cur_group = '0;
  logic list_on = 1'b0;

  cmd_t pending_cmds[$];
  vcqc_pkg::res_t item_beats[$];
  vcqc_pkg::res_t expected_beats[$];

  int error_count = 0;
  int stim_count = 0;
  int idle_cycles = 0;
  int gap_max = 0;
  int gap_left = 0;
  int burst_left = 0;
  bit in_beat_taken = 1'b0;
  logic [15:0] ready_mask = 16'hFFFF;
  logic [3:0] mask_pos = '0;
  int hold_req = 0;
  int hold_served = 0;
  int hold_left = 0;

  voice_command_queue_controller_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_mode(in_mode),
    .in_voice_index(in_voice_index),
    .in_wait_flag(in_wait_flag),
    .in_language(in_language),
    .in_group_number(in_group_number),
    .in_volume_level(in_volume_level),
    .in_device_busy(in_device_busy),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_frame_valid(out_frame_valid),
    .out_frame_bits(out_frame_bits),
    .out_frame_word(out_frame_word),
    .out_status(out_status),
    .out_last(out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  task automatic report_error(input string msg);
    error_count++;
    $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [11:0] got,
                             input logic [11:0] want);
    if (got !== want) begin
      report_error($sformatf("%s mismatch: got %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic emit_frame(input logic [3:0] bits, input logic [11:0] word);
    item_beats.push_back('{1'b1, bits, word, vcqc_pkg::ST_OK, 1'b0});
  endtask

  task automatic emit_group(input logic [3:0] g);
    if (g inside {[vcqc_pkg::GROUP_MIN:vcqc_pkg::GROUP_MAX]}) begin
      cur_group = g;
      emit_frame(vcqc_pkg::BITS_8, vcqc_pkg::FRM_SEL_GROUP | g);
    end
  endtask

  // The play frame is dropped while no valid group has been selected.
  task automatic emit_voice(input logic [7:0] idx);
    emit_frame(vcqc_pkg::BITS_12, vcqc_pkg::FRM_SEL_VOICE | idx);
    if (cur_group inside {[vcqc_pkg::GROUP_MIN:vcqc_pkg::GROUP_MAX]}) begin
      emit_frame(vcqc_pkg::BITS_8, vcqc_pkg::FRM_PLAY_GROUP | cur_group);
    end
  endtask

  task automatic predict_command(input cmd_t c);
    logic [1:0] st;
    logic idx_ok;
    vcqc_pkg::entry_t head;
    st = vcqc_pkg::ST_OK;
    idx_ok = (c.voice_index >= vcqc_pkg::INDEX_MIN) &&
             (c.voice_index <= vcqc_pkg::INDEX_MAX);
    item_beats.delete();
    case (c.mode)
      vcqc_pkg::MODE_APPEND: begin
        if (!idx_ok) st = vcqc_pkg::ST_RANGE;
        else if (request_fifo.size() >= vcqc_pkg::QUEUE_DEPTH_DEF) st = vcqc_pkg::ST_FULL;
        else begin
          request_fifo.push_back('{language: c.language, wait_flag: c.wait_flag,
                                   voice_index: c.voice_index});
        end
      end
      vcqc_pkg::MODE_TICK: begin
        if (request_fifo.size() != 0 && list_on) begin
          head = request_fifo[0];
          if (head.wait_flag && c.device_busy) st = vcqc_pkg::ST_BUSY;
          else begin
            emit_group(lang_group[head.language]);
            emit_voice(head.voice_index);
            void'(request_fifo.pop_front());
          end
        end
      end
      vcqc_pkg::MODE_PLAY_NOW: begin
        if (!idx_ok) st = vcqc_pkg::ST_RANGE;
        else if (c.wait_flag && c.device_busy) st = vcqc_pkg::ST_BUSY;
        else emit_voice(c.voice_index);
      end
      vcqc_pkg::MODE_SEL_GROUP: begin
        if (!(c.group_number inside {[vcqc_pkg::GROUP_MIN:vcqc_pkg::GROUP_MAX]})) begin
          st = vcqc_pkg::ST_RANGE;
        end else emit_group(c.group_number);
      end
      vcqc_pkg::MODE_VOLUME: begin
        if (c.volume_level > vcqc_pkg::VOLUME_MAX) st = vcqc_pkg::ST_RANGE;
        else begin
          emit_frame(vcqc_pkg::BITS_4, vcqc_pkg::FRM_PAUSE);
          emit_frame(vcqc_pkg::BITS_8, vcqc_pkg::FRM_VOLUME | c.volume_level);
          emit_frame(vcqc_pkg::BITS_4, vcqc_pkg::FRM_RESUME);
          list_on = 1'b1;
        end
      end
      vcqc_pkg::MODE_PAUSE: begin
        list_on = 1'b0;
        emit_frame(vcqc_pkg::BITS_4, vcqc_pkg::FRM_PAUSE);
      end
      vcqc_pkg::MODE_RESUME: begin
        list_on = 1'b1;
        emit_frame(vcqc_pkg::BITS_4, vcqc_pkg::FRM_RESUME);
      end
      vcqc_pkg::MODE_STOP: begin
        list_on = 1'b0;
        emit_frame(vcqc_pkg::BITS_4, vcqc_pkg::FRM_STOP);
      end
      vcqc_pkg::MODE_START_LIST: list_on = 1'b1;
      vcqc_pkg::MODE_STOP_LIST: list_on = 1'b0;
      vcqc_pkg::MODE_CLEAR: begin
        request_fifo.delete();
        list_on = 1'b0;
      end
      default: st = vcqc_pkg::ST_RANGE;
    endcase
    if (item_beats.size() == 0) item_beats.push_back('{1'b0, 4'd0, 12'd0, st, 1'b0});
    item_beats[item_beats.size() - 1].last = 1'b1;
    foreach (item_beats[k]) expected_beats.push_back(item_beats[k]);
  endtask

  task automatic check_beat();
    vcqc_pkg::res_t got;
    vcqc_pkg::res_t want;
    got = '{out_frame_valid, out_frame_bits, out_frame_word, out_status, out_last};
    if (expected_beats.size() == 0) begin
      report_error($sformatf("result beat %0h with nothing expected", got));
      return;
    end
    want = expected_beats.pop_front();
    check_field("frame_valid", got.frame_valid, want.frame_valid);
    check_field("frame_bits", got.frame_bits, want.frame_bits);
    check_field("frame_word", got.frame_word, want.frame_word);
    check_field("status", got.status, want.status);
    check_field("last", got.last, want.last);
  endtask

  // Monitor, input-side predictor and watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) check_beat();
      if (in_valid && in_ready) begin
        predict_command('{in_mode, in_voice_index, in_wait_flag, in_language,
                          in_group_number, in_volume_level, in_device_busy});
        in_beat_taken = 1'b1;
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sender: bursts of items separated by random gaps.
  always @(negedge clk) begin
    cmd_t c;
    if (in_valid && !in_beat_taken) begin
      // Beat still waiting to be taken; hold it.
    end else begin
      in_beat_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        c = pending_cmds.pop_front();
        in_valid <= 1'b1;
        in_mode <= c.mode;
        in_voice_index <= c.voice_index;
        in_wait_flag <= c.wait_flag;
        in_language <= c.language;
        in_group_number <= c.group_number;
        in_volume_level <= c.volume_level;
        in_device_busy <= c.device_busy;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(8, 1);
          gap_left = $urandom_range(gap_max);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: rotating stall pattern, with one long hold-off.
  always @(negedge clk) begin
    if (hold_served != hold_req) begin
      hold_served = hold_req;
      hold_left = LONG_HOLD;
    end
    mask_pos++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ready_mask[mask_pos];
    end
  end

  task automatic offer(input cmd_t c);
    pending_cmds.push_back(c);
    stim_count++;
  endtask

  task automatic queue_cmd(input logic [3:0] mode, input logic [7:0] vidx, input logic wt,
                           input logic lang, input logic [3:0] grp, input logic [3:0] vol,
                           input logic busy);
    offer('{mode, vidx, wt, lang, grp, vol, busy});
  endtask

  function automatic cmd_t random_cmd();
    cmd_t c;
    c.mode = 4'($urandom_range(15));
    c.voice_index = 8'($urandom_range(255));
    c.wait_flag = 1'($urandom_range(1));
    c.language = 1'($urandom_range(1));
    c.group_number = 4'($urandom_range(15));
    c.volume_level = 4'($urandom_range(15));
    c.device_busy = 1'($urandom_range(1));
    return c;
  endfunction

  // A random command, or a run of appends, a list enable, then a run of mostly ticks.
  task automatic queue_session();
    cmd_t c;
    int n_append;
    int n_tick;
    if ($urandom_range(99) < 15) begin
      offer(random_cmd());
      return;
    end
    n_append = $urandom_range(10, 1);
    repeat (n_append) begin
      c = random_cmd();
      c.mode = vcqc_pkg::MODE_APPEND;
      c.voice_index = 8'($urandom_range(vcqc_pkg::INDEX_MAX, vcqc_pkg::INDEX_MIN));
      if ($urandom_range(19) == 0) c.voice_index = $urandom_range(1) ? 8'h00 : 8'hFF;
      offer(c);
    end
    c = random_cmd();
    case ($urandom_range(3))
      0: c.mode = vcqc_pkg::MODE_RESUME;
      1: begin
        c.mode = vcqc_pkg::MODE_VOLUME;
        c.volume_level = 4'($urandom_range(vcqc_pkg::VOLUME_MAX));
      end
      default: c.mode = vcqc_pkg::MODE_START_LIST;
    endcase
    offer(c);
    n_tick = $urandom_range(10, 1);
    repeat (n_tick) begin
      c = random_cmd();
      case ($urandom_range(9))
        0: c.mode = vcqc_pkg::MODE_PLAY_NOW;
        1: c.mode = vcqc_pkg::MODE_SEL_GROUP;
        2: c.mode = vcqc_pkg::MODE_VOLUME;
        default: c.mode = vcqc_pkg::MODE_TICK;
      endcase
      offer(c);
    end
    if ($urandom_range(3) == 0) begin
      c = random_cmd();
      case ($urandom_range(3))
        0: c.mode = vcqc_pkg::MODE_PAUSE;
        1: c.mode = vcqc_pkg::MODE_STOP;
        2: c.mode = vcqc_pkg::MODE_STOP_LIST;
        default: c.mode = vcqc_pkg::MODE_CLEAR;
      endcase
      offer(c);
    end
  endtask

  task automatic wait_all_results();
    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_register(input logic [vcqc_pkg::CFG_IDX_W-1:0] idx,
                                input logic [3:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    if (idx == vcqc_pkg::REG_CHINESE_GROUP) lang_group[0] = data;
    else if (idx == vcqc_pkg::REG_ENGLISH_GROUP) lang_group[1] = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [3:0] chinese_sweep[6];
    logic [3:0] english_sweep[6];
    int base;
    chinese_sweep = '{4'd1, 4'd0, 4'd8, 4'd15, 4'd9, 4'd3};
    english_sweep = '{4'd8, 4'd15, 4'd1, 4'd0, 4'd2, 4'd9};
    chinese_sweep[4] = 4'($urandom_range(15));
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, with both language groups at their reset value.
    gap_max = 3;
    queue_cmd(vcqc_pkg::MODE_TICK, 8'd0, 1'b0, 1'b0, 4'd0, 4'd0, 1'b0);
    queue_cmd(vcqc_pkg::MODE_APPEND, 8'h00, 1'b0, 1'b0, 4'd0, 4'd0, 1'b0);
    queue_cmd(vcqc_pkg::MODE_APPEND, 8'hFF, 1'b0, 1'b0, 4'd0, 4'd0, 1'b0);
    // No group selected yet, so only the voice select frame goes out.
    queue_cmd(vcqc_pkg::MODE_PLAY_NOW, 8'd77, 1'b0, 1'b0, 4'd0, 4'd0, 1'b0);
    queue_cmd(vcqc_pkg::MODE_APPEND, vcqc_pkg::INDEX_MIN, 1'b0, 1'b0, 4'd0, 4'd0, 1'b0);
    queue_cmd(vcqc_pkg::MODE_APPEND, vcqc_pkg::INDEX_MAX, 1'b1, 1'b1, 4'd0, 4'd0, 1'b0);
    queue_cmd(vcqc_pkg::MODE_TICK, 8'd0, 1'b0, 1'b0, 4'd0, 4'd0, 1'b0);
    queue_cmd(vcqc_pkg::MODE_START_LIST, 8'd0, 1'b0, 1'b0, 4'd0, 4'd0, 1'b0);
    queue_cmd(vcqc_pkg::MODE_TICK, 8'd0, 1'b0, 1'b0, 4'd0, 4'd0, 1'b1);
    queue_cmd(vcqc_pkg::MODE_TICK, 8'd0, 1'b0, 1'b0, 4'd0, 4'd0, 1'b1);
    queue_cmd(vcqc_pkg::MODE_TICK, 8'd0, 1'b0, 1'b0, 4'd0, 4'd0, 1'b0);
    queue_cmd(vcqc_pkg::MODE_PLAY_NOW, 8'h00, 1'b0, 1'b0, 4'd0, 4'd0, 1'b0);
    queue_cmd(vcqc_pkg::MODE_PLAY_NOW, 8'hFF, 1'b1, 1'b0, 4'd0, 4'd0, 1'b1);
    queue_cmd(vcqc_pkg::MODE_PLAY_NOW, 8'd200, 1'b1, 1'b0, 4'd0, 4'd0, 1'b1);
    queue_cmd(vcqc_pkg::MODE_SEL_GROUP, 8'd0, 1'b0, 1'b0, 4'd0, 4'd0, 1'b0);
    queue_cmd(vcqc_pkg::MODE_SEL_GROUP, 8'd0, 1'b0, 1'b0, 4'd9, 4'd0, 1'b0);
    queue_cmd(vcqc_pkg::MODE_SEL_GROUP, 8'd0, 1'b0, 1'b0, vcqc_pkg::GROUP_MIN, 4'd0, 1'b0);
    queue_cmd(vcqc_pkg::MODE_SEL_GROUP, 8'd0, 1'b0, 1'b0, vcqc_pkg::GROUP_MAX, 4'd0, 1'b0);
    queue_cmd(vcqc_pkg::MODE_VOLUME, 8'd0, 1'b0, 1'b0, 4'd0, 4'd8, 1'b0);
    queue_cmd(vcqc_pkg::MODE_VOLUME, 8'd0, 1'b0, 1'b0, 4'd0, 4'd0, 1'b0);
    queue_cmd(vcqc_pkg::MODE_VOLUME, 8'd0, 1'b0, 1'b0, 4'd0, vcqc_pkg::VOLUME_MAX, 1'b0);
    queue_cmd(vcqc_pkg::MODE_PAUSE, 8'd0, 1'b0, 1'b0, 4'd0, 4'd0, 1'b0);
    queue_cmd(vcqc_pkg::MODE_RESUME, 8'd0, 1'b0, 1'b0, 4'd0, 4'd0, 1'b0);
    queue_cmd(vcqc_pkg::MODE_STOP, 8'd0, 1'b0, 1'b0, 4'd0, 4'd0, 1'b0);
    queue_cmd(vcqc_pkg::MODE_STOP_LIST, 8'd0, 1'b0, 1'b0, 4'd0, 4'd0, 1'b0);
    queue_cmd(vcqc_pkg::MODE_CLEAR, 8'd0, 1'b0, 1'b0, 4'd0, 4'd0, 1'b0);
    queue_cmd(MODE_UNKNOWN_LO, 8'd0, 1'b0, 1'b0, 4'd0, 4'd0, 1'b0);
    queue_cmd(MODE_UNKNOWN_HI, 8'd0, 1'b0, 1'b0, 4'd0, 4'd0, 1'b0);
    base = stim_count;

    // Random phases, each started from an idle block with new group settings.
    for (int ph = 0; ph < 6; ph++) begin
      wait_all_results();
      write_register(vcqc_pkg::REG_CHINESE_GROUP, chinese_sweep[ph]);
      write_register(vcqc_pkg::REG_ENGLISH_GROUP, english_sweep[ph]);
      if (ph == 4) begin
        write_register(REG_UNUSED_LO, 4'd1);
        write_register(REG_UNUSED_HI, 4'd15);
      end
      if (ph % 3 == 1) begin
        gap_max = 0;
        ready_mask = 16'hFFFF;
      end else begin
        gap_max = $urandom_range(8, 2);
        ready_mask = 16'($urandom) | (16'd1 << $urandom_range(15));
      end
      // The receiver holds off for a long stretch while the sender keeps offering.
      if (ph == 2) begin
        gap_max = 0;
        hold_req++;
      end
      while (stim_count < base + (ph + 1) * RANDOM_PER_PHASE) queue_session();
    end

    wait_all_results();
    repeat (12) @(posedge clk);
    if (error_count == 0 && expected_beats.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
